>>> hw/rtl/lpc_pkg.sv
// ----------------------------------------------------------------------------
// lpc_pkg
// Shared types and panel command codes for the line pixel command stream.
// ----------------------------------------------------------------------------
package lpc_pkg;

    localparam int BUS_W = 16;

    localparam logic OP_BEGIN   = 1'b0;
    localparam logic OP_ADVANCE = 1'b1;

    localparam logic [BUS_W-1:0] CMD_COLUMN = 16'h002A;
    localparam logic [BUS_W-1:0] CMD_PAGE   = 16'h002B;
    localparam logic [BUS_W-1:0] CMD_WRITE  = 16'h002C;

    localparam logic [2:0] WORD_COL_CMD = 3'd0;
    localparam logic [2:0] WORD_COL_HI  = 3'd1;
    localparam logic [2:0] WORD_COL_LO  = 3'd2;
    localparam logic [2:0] WORD_PAGE_CMD = 3'd3;
    localparam logic [2:0] WORD_PAGE_HI = 3'd4;
    localparam logic [2:0] WORD_PAGE_LO = 3'd5;
    localparam logic [2:0] WORD_WR_CMD  = 3'd6;
    localparam logic [2:0] WORD_COLOUR  = 3'd7;

    typedef struct packed {
        logic [BUS_W-1:0] px;
        logic [BUS_W-1:0] py;
        logic [BUS_W-1:0] colour_n;
        logic             done;
    } t_pixel;

endpackage

>>> hw/rtl/lpc_cmd_if.sv
// ----------------------------------------------------------------------------
// lpc_cmd_if
// Command channel: begin or advance transactions with line endpoints.
// ----------------------------------------------------------------------------
interface lpc_cmd_if;
    logic        valid;
    logic        ready;
    logic        operation;
    logic [15:0] x_start;
    logic [15:0] y_start;
    logic [15:0] x_end;
    logic [15:0] y_end;
    logic [15:0] color;

    modport source (
        output valid, operation, x_start, y_start, x_end, y_end, color,
        input  ready
    );
    modport sink (
        input  valid, operation, x_start, y_start, x_end, y_end, color,
        output ready
    );
endinterface

>>> hw/rtl/lpc_word_if.sv
// ----------------------------------------------------------------------------
// lpc_word_if
// Panel bus channel: one bus word per transaction.
// ----------------------------------------------------------------------------
interface lpc_word_if;
    logic        valid;
    logic        ready;
    logic        is_data;
    logic [15:0] bus_word;
    logic        last_of_pixel;
    logic        line_finished;

    modport source (
        output valid, is_data, bus_word, last_of_pixel, line_finished,
        input  ready
    );
    modport sink (
        input  valid, is_data, bus_word, last_of_pixel, line_finished,
        output ready
    );
endinterface

>>> hw/rtl/lpc_front.sv
// ----------------------------------------------------------------------------
// lpc_front
// Accepts command transactions, holds the Bresenham state and issues one
// pixel record per advance of an active line.
// ----------------------------------------------------------------------------
module lpc_front #(
    parameter int COORD_WIDTH = 16
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    lpc_cmd_if.sink         i_cmd,
    output logic            o_push,
    input  logic            i_push_ready,
    output lpc_pkg::t_pixel o_pixel
);
    import lpc_pkg::*;

    localparam int CW = COORD_WIDTH;
    localparam int DW = CW + 1;
    localparam int EW = CW + 3;

    logic [CW-1:0]        r_cur_x, r_cur_y, r_tgt_x, r_tgt_y;
    logic [DW-1:0]        r_dx;
    logic signed [DW-1:0] r_ndy;
    logic                 r_sx_neg, r_sy_neg;
    logic signed [EW-1:0] r_err;
    logic [BUS_W-1:0]     r_colour;
    logic                 r_line_active;

    logic [CW-1:0]        x0, y0, x1, y1;
    logic [DW-1:0]        abs_dx, abs_dy;
    logic signed [EW-1:0] dx_e, ndy_e;
    logic signed [EW:0]   e2, dx_e2, ndy_e2;
    logic                 c1, c2, x_hit, y_hit, step_x, step_y, done;
    logic signed [EW-1:0] n_err;
    logic                 w_accept;

    assign i_cmd.ready = i_push_ready;
    assign w_accept    = i_cmd.valid && i_cmd.ready;
    assign o_push      = w_accept && (i_cmd.operation == OP_ADVANCE) && r_line_active;

    assign x0 = i_cmd.x_start[CW-1:0];
    assign y0 = i_cmd.y_start[CW-1:0];
    assign x1 = i_cmd.x_end[CW-1:0];
    assign y1 = i_cmd.y_end[CW-1:0];

    always_comb begin
        abs_dx = (x1 >= x0) ? DW'(x1 - x0) : DW'(x0 - x1);
        abs_dy = (y1 >= y0) ? DW'(y1 - y0) : DW'(y0 - y1);
    end

    assign dx_e   = $signed({2'b00, r_dx});
    assign ndy_e  = EW'(r_ndy);
    assign e2     = {r_err, 1'b0};
    assign dx_e2  = (EW + 1)'(dx_e);
    assign ndy_e2 = (EW + 1)'(ndy_e);

    always_comb begin
        x_hit  = (r_cur_x == r_tgt_x);
        y_hit  = (r_cur_y == r_tgt_y);
        c1     = (e2 >= ndy_e2);
        step_x = c1 && !x_hit;
        c2     = !(c1 && x_hit) && (e2 <= dx_e2);
        step_y = c2 && !y_hit;
        done   = (c1 && x_hit) || (c2 && y_hit);
        n_err  = r_err + (step_x ? ndy_e : '0) + (step_y ? dx_e : '0);
    end

    always_comb begin
        o_pixel.px       = BUS_W'(r_cur_x);
        o_pixel.py       = BUS_W'(r_cur_y);
        o_pixel.colour_n = ~r_colour;
        o_pixel.done     = done;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur_x       <= '0;
            r_cur_y       <= '0;
            r_tgt_x       <= '0;
            r_tgt_y       <= '0;
            r_dx          <= '0;
            r_ndy         <= '0;
            r_sx_neg      <= 1'b0;
            r_sy_neg      <= 1'b0;
            r_err         <= '0;
            r_colour      <= '0;
            r_line_active <= 1'b0;
        end else if (w_accept && (i_cmd.operation == OP_BEGIN)) begin
            r_cur_x       <= x0;
            r_cur_y       <= y0;
            r_tgt_x       <= x1;
            r_tgt_y       <= y1;
            r_dx          <= abs_dx;
            r_ndy         <= -$signed(abs_dy);
            r_sx_neg      <= !(x0 < x1);
            r_sy_neg      <= !(y0 < y1);
            r_err         <= $signed({2'b00, abs_dx}) - $signed({2'b00, abs_dy});
            r_colour      <= i_cmd.color;
            r_line_active <= 1'b1;
        end else if (o_push) begin
            r_err <= n_err;
            if (step_x) begin
                r_cur_x <= r_sx_neg ? r_cur_x - 1'b1 : r_cur_x + 1'b1;
            end
            if (step_y) begin
                r_cur_y <= r_sy_neg ? r_cur_y - 1'b1 : r_cur_y + 1'b1;
            end
            if (done) begin
                r_line_active <= 1'b0;
            end
        end
    end

    a_push_active: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_push |-> r_line_active)
        else $error("pixel issued while no line active");

    a_done_idles: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_push && done) |=> !r_line_active || $past(w_accept && !o_push))
        else $error("line still active after final pixel");

endmodule

>>> hw/rtl/lpc_queue.sv
// ----------------------------------------------------------------------------
// lpc_queue
// Two-entry pixel record queue between the command front and the bus back.
// ----------------------------------------------------------------------------
module lpc_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    output logic            o_push_ready,
    input  lpc_pkg::t_pixel i_pixel,
    output logic            o_pop_valid,
    input  logic            i_pop,
    output lpc_pkg::t_pixel o_pixel
);
    import lpc_pkg::*;

    t_pixel     r_mem [2];
    logic       r_wr_ptr, r_rd_ptr;
    logic [1:0] r_count;
    logic       w_wr, w_rd;

    assign o_push_ready = (r_count != 2'd2);
    assign o_pop_valid  = (r_count != 2'd0);
    assign o_pixel      = r_mem[r_rd_ptr];
    assign w_wr         = i_push && o_push_ready;
    assign w_rd         = i_pop && o_pop_valid;

    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_mem[r_wr_ptr] <= i_pixel;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (w_wr) begin
                r_wr_ptr <= !r_wr_ptr;
            end
            if (w_rd) begin
                r_rd_ptr <= !r_rd_ptr;
            end
            case ({w_wr, w_rd})
                2'b10:   r_count <= r_count + 2'd1;
                2'b01:   r_count <= r_count - 2'd1;
                default: r_count <= r_count;
            endcase
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count != 2'd3)
        else $error("queue count out of range");

    a_ptr_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_count == 2'd0) || (r_count == 2'd2)) |-> (r_wr_ptr == r_rd_ptr))
        else $error("queue pointers disagree with count");

endmodule

>>> hw/rtl/lpc_back.sv
// ----------------------------------------------------------------------------
// lpc_back
// Serialises each pixel record into the eight-word panel bus sequence.
// ----------------------------------------------------------------------------
module lpc_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_pop_valid,
    output logic            o_pop,
    input  lpc_pkg::t_pixel i_pixel,
    lpc_word_if.source      o_word
);
    import lpc_pkg::*;

    t_pixel     r_pix;
    logic       r_busy;
    logic [2:0] r_idx;
    logic       w_take, w_last;

    assign o_word.valid = r_busy;
    assign w_take       = o_word.valid && o_word.ready;
    assign w_last       = w_take && (r_idx == WORD_COLOUR);
    assign o_pop        = !r_busy || w_last;

    always_comb begin
        o_word.is_data       = 1'b1;
        o_word.bus_word      = r_pix.px;
        o_word.last_of_pixel = 1'b0;
        o_word.line_finished = 1'b0;
        unique case (r_idx)
            WORD_COL_CMD: begin
                o_word.is_data  = 1'b0;
                o_word.bus_word = CMD_COLUMN;
            end
            WORD_COL_HI, WORD_COL_LO: begin
                o_word.bus_word = r_pix.px;
            end
            WORD_PAGE_CMD: begin
                o_word.is_data  = 1'b0;
                o_word.bus_word = CMD_PAGE;
            end
            WORD_PAGE_HI, WORD_PAGE_LO: begin
                o_word.bus_word = r_pix.py;
            end
            WORD_WR_CMD: begin
                o_word.is_data  = 1'b0;
                o_word.bus_word = CMD_WRITE;
            end
            WORD_COLOUR: begin
                o_word.bus_word      = r_pix.colour_n;
                o_word.last_of_pixel = 1'b1;
                o_word.line_finished = r_pix.done;
            end
            default: begin
                o_word.bus_word = r_pix.px;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (o_pop && i_pop_valid) begin
            r_pix <= i_pixel;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_idx  <= WORD_COL_CMD;
        end else if (o_pop) begin
            r_busy <= i_pop_valid;
            r_idx  <= WORD_COL_CMD;
        end else if (w_take) begin
            r_idx <= r_idx + 3'd1;
        end
    end

    a_idle_idx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_busy |-> (r_idx == WORD_COL_CMD))
        else $error("word index moved while idle");

    a_drain_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_last && !i_pop_valid) |=> !r_busy)
        else $error("back still busy after final word with empty queue");

endmodule

>>> hw/rtl/line_pixel_command_stream.sv
// ----------------------------------------------------------------------------
// line_pixel_command_stream
// Bresenham line walker emitting panel column/page/write bus sequences.
// ----------------------------------------------------------------------------
// A begin transaction loads the endpoints and colour and yields no bus
// words; each advance transaction of an active line yields eight bus words,
// one per cycle while the bus is ready, from the serialiser in the back end.
// The front end takes one command transaction per cycle while its two-entry
// pixel queue has room, so up to three advances can be absorbed while the
// bus is stalled: one held in the serialiser and two in the queue.
// Advances while idle are consumed and yield nothing; a begin during a
// line restarts it.
// ----------------------------------------------------------------------------
module line_pixel_command_stream #(
    parameter int COORD_WIDTH = 16
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    lpc_cmd_if.sink    i_cmd,
    lpc_word_if.source o_word
);
    import lpc_pkg::*;

    logic   w_push, w_push_ready, w_pop_valid, w_pop;
    t_pixel w_front_pix, w_queue_pix;

    lpc_front #(
        .COORD_WIDTH (COORD_WIDTH)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (i_cmd),
        .o_push       (w_push),
        .i_push_ready (w_push_ready),
        .o_pixel      (w_front_pix)
    );

    lpc_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (w_push),
        .o_push_ready (w_push_ready),
        .i_pixel      (w_front_pix),
        .o_pop_valid  (w_pop_valid),
        .i_pop        (w_pop),
        .o_pixel      (w_queue_pix)
    );

    lpc_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_pop_valid (w_pop_valid),
        .o_pop       (w_pop),
        .i_pixel     (w_queue_pix),
        .o_word      (o_word)
    );

endmodule

>>> test/tb_line_pixel_command_stream.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_line_pixel_command_stream
// Self-checking bench for the Bresenham line pixel command stream.
// ----------------------------------------------------------------------------
// Command transactions are driven on the falling edge; both channels are
// sampled on the rising edge. Every accepted command is run through a line
// walker kept in the bench, which queues the eight bus words each drawn pixel
// must produce, and each bus word taken from the block is checked against the
// head of that queue. A short table of directed commands (reset state, single
// point lines at both coordinate extremes, advances while idle, a restart in
// mid-line) is followed by random lines, broken lines and noise, with random
// idling on both channels, one long bus stall and pauses until the bus drains.
// ----------------------------------------------------------------------------
module tb_line_pixel_command_stream;
    import lpc_pkg::*;

    localparam int COORD_W      = 16;
    localparam int RANDOM_ITEMS = 200;
    localparam int HOLD_CYCLES  = 300;
    localparam int SETTLE       = 40;

    typedef enum logic [1:0] {
        CHK_MODEL,
        CHK_NONE,
        CHK_PIXEL
    } chk_e;

    typedef struct packed {
        logic        op;
        logic [15:0] xs;
        logic [15:0] ys;
        logic [15:0] xe;
        logic [15:0] ye;
        logic [15:0] col;
    } cmd_t;

    typedef struct packed {
        cmd_t   cmd;
        chk_e   chk;
        t_pixel pix;
    } row_t;

    typedef struct packed {
        logic        is_data;
        logic [15:0] word;
        logic        last;
        logic        fin;
    } bus_word_t;

    logic i_clk = 1'b0;
    logic i_rst_n;

    lpc_cmd_if  cmd_if();
    lpc_word_if word_if();

    line_pixel_command_stream #(
        .COORD_WIDTH(COORD_W)
    ) dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_cmd  (cmd_if),
        .o_word (word_if)
    );

    always #6 i_clk = ~i_clk;

    // line walker state
    logic [COORD_W-1:0] pos_x = '0, pos_y = '0, end_x = '0, end_y = '0;
    logic signed [16:0] span_x = '0, span_y_neg = '0;
    logic signed [18:0] err_acc = '0;
    logic               x_back = 1'b0, y_back = 1'b0;
    logic [15:0]        ink = '0;
    logic               drawing = 1'b0;

    bus_word_t pending_bus_words[$];
    int        fail_count   = 0;
    int        useful_items = 0;
    bit        gaps_on      = 1'b1;
    bit        hold_req     = 1'b0;
    int        hold_cnt     = 0;
    chk_e      drv_chk      = CHK_MODEL;
    t_pixel    drv_pix      = '0;

    row_t plan[25];

    task automatic bresenham_next_pixel(input cmd_t c, output bit emitted,
                                        output t_pixel pix);
        logic [COORD_W-1:0] x0, y0, x1, y1, dxa, dya;
        logic signed [19:0] twice_err;
        bit                 ended;
        emitted = 1'b0;
        pix     = '0;
        ended   = 1'b0;
        x0 = c.xs[COORD_W-1:0];
        y0 = c.ys[COORD_W-1:0];
        x1 = c.xe[COORD_W-1:0];
        y1 = c.ye[COORD_W-1:0];
        if (c.op == OP_BEGIN) begin
            pos_x = x0;
            pos_y = y0;
            end_x = x1;
            end_y = y1;
            dxa = (x1 >= x0) ? x1 - x0 : x0 - x1;
            dya = (y1 >= y0) ? y1 - y0 : y0 - y1;
            span_x     = {1'b0, dxa};
            span_y_neg = -$signed({1'b0, dya});
            x_back  = !(x0 < x1);
            y_back  = !(y0 < y1);
            err_acc = span_x + span_y_neg;
            ink     = c.col;
            drawing = 1'b1;
        end else if (drawing) begin
            pix.px       = pos_x;
            pix.py       = pos_y;
            pix.colour_n = ~ink;
            twice_err    = err_acc <<< 1;
            if (twice_err >= span_y_neg) begin
                if (pos_x == end_x) begin
                    ended = 1'b1;
                end else begin
                    err_acc = err_acc + span_y_neg;
                    pos_x   = x_back ? pos_x - 1'b1 : pos_x + 1'b1;
                end
            end
            if (!ended && twice_err <= span_x) begin
                if (pos_y == end_y) begin
                    ended = 1'b1;
                end else begin
                    err_acc = err_acc + span_x;
                    pos_y   = y_back ? pos_y - 1'b1 : pos_y + 1'b1;
                end
            end
            if (ended) drawing = 1'b0;
            pix.done = ended;
            emitted  = 1'b1;
        end
    endtask

    task automatic push_pixel_words(input t_pixel p);
        pending_bus_words.push_back('{1'b0, CMD_COLUMN, 1'b0, 1'b0});
        pending_bus_words.push_back('{1'b1, p.px, 1'b0, 1'b0});
        pending_bus_words.push_back('{1'b1, p.px, 1'b0, 1'b0});
        pending_bus_words.push_back('{1'b0, CMD_PAGE, 1'b0, 1'b0});
        pending_bus_words.push_back('{1'b1, p.py, 1'b0, 1'b0});
        pending_bus_words.push_back('{1'b1, p.py, 1'b0, 1'b0});
        pending_bus_words.push_back('{1'b0, CMD_WRITE, 1'b0, 1'b0});
        pending_bus_words.push_back('{1'b1, p.colour_n, 1'b1, p.done});
    endtask

    // predict on accepted commands, check accepted bus words
    always @(posedge i_clk) begin : monitor
        bit        emitted;
        t_pixel    pix;
        bus_word_t got, want;
        if (i_rst_n && cmd_if.valid && cmd_if.ready) begin
            if (cmd_if.operation == OP_BEGIN || drawing) useful_items++;
            bresenham_next_pixel('{cmd_if.operation, cmd_if.x_start, cmd_if.y_start,
                                   cmd_if.x_end, cmd_if.y_end, cmd_if.color},
                                 emitted, pix);
            if (drv_chk == CHK_PIXEL)
                push_pixel_words(drv_pix);
            else if (drv_chk == CHK_MODEL && emitted)
                push_pixel_words(pix);
        end
        if (i_rst_n && word_if.valid && word_if.ready) begin
            got = '{word_if.is_data, word_if.bus_word, word_if.last_of_pixel,
                    word_if.line_finished};
            if (pending_bus_words.size() == 0) begin
                $display({"%0t: unexpected bus word: expected none, ",
                          "got data=%0b word=%h last=%0b fin=%0b"},
                         $time, got.is_data, got.word, got.last, got.fin);
                fail_count++;
            end else begin
                want = pending_bus_words.pop_front();
                if (got.is_data !== want.is_data || got.word !== want.word ||
                    got.last !== want.last || got.fin !== want.fin) begin
                    $display({"%0t: bus word mismatch: expected data=%0b word=%h ",
                              "last=%0b fin=%0b, got data=%0b word=%h last=%0b fin=%0b"},
                             $time, want.is_data, want.word, want.last, want.fin,
                             got.is_data, got.word, got.last, got.fin);
                    fail_count++;
                end
            end
        end
    end

    // bus receiver: random idling, or a long stall on request
    initial begin
        word_if.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                hold_req = 1'b0;
                hold_cnt = HOLD_CYCLES;
            end
            if (hold_cnt != 0) begin
                hold_cnt--;
                word_if.ready <= 1'b0;
            end else begin
                word_if.ready <= !(gaps_on && $urandom_range(99) < 23);
            end
        end
    end

    function automatic cmd_t random_cmd(input logic op);
        cmd_t c;
        c.op  = op;
        c.xs  = 16'($urandom);
        c.ys  = 16'($urandom);
        c.xe  = 16'($urandom);
        c.ye  = 16'($urandom);
        c.col = 16'($urandom);
        return c;
    endfunction

    task automatic issue_command(input cmd_t c, input chk_e k = CHK_MODEL,
                                 input t_pixel p = '0);
        @(negedge i_clk);
        while (gaps_on && $urandom_range(99) < 23) begin
            cmd_if.valid <= 1'b0;
            @(negedge i_clk);
        end
        cmd_if.valid     <= 1'b1;
        cmd_if.operation <= c.op;
        cmd_if.x_start   <= c.xs;
        cmd_if.y_start   <= c.ys;
        cmd_if.x_end     <= c.xe;
        cmd_if.y_end     <= c.ye;
        cmd_if.color     <= c.col;
        drv_chk          <= k;
        drv_pix          <= p;
        do @(posedge i_clk); while (!cmd_if.ready);
    endtask

    // drop valid and hold until every queued bus word has arrived
    task automatic wait_bus_drained();
        @(negedge i_clk);
        cmd_if.valid <= 1'b0;
        while (pending_bus_words.size() != 0) @(posedge i_clk);
    endtask

    initial begin
        plan = '{
            '{'{OP_ADVANCE, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF}, CHK_NONE, '0},
            '{'{OP_BEGIN, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000}, CHK_NONE, '0},
            '{'{OP_ADVANCE, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000}, CHK_PIXEL,
              '{16'h0000, 16'h0000, 16'hFFFF, 1'b1}},
            '{'{OP_ADVANCE, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000}, CHK_NONE, '0},
            '{'{OP_BEGIN, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF}, CHK_NONE, '0},
            '{'{OP_ADVANCE, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF}, CHK_PIXEL,
              '{16'hFFFF, 16'hFFFF, 16'h0000, 1'b1}},
            '{'{OP_BEGIN, 16'h0000, 16'h0000, 16'h0003, 16'h0000, 16'h1234}, CHK_NONE, '0},
            '{'{OP_ADVANCE, 16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555}, CHK_MODEL, '0},
            '{'{OP_ADVANCE, 16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA}, CHK_MODEL, '0},
            '{'{OP_ADVANCE, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000}, CHK_MODEL, '0},
            '{'{OP_ADVANCE, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF}, CHK_MODEL, '0},
            '{'{OP_BEGIN, 16'h0005, 16'h0009, 16'h0005, 16'h0006, 16'h8001}, CHK_NONE, '0},
            '{'{OP_ADVANCE, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000}, CHK_MODEL, '0},
            '{'{OP_ADVANCE, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000}, CHK_MODEL, '0},
            '{'{OP_ADVANCE, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000}, CHK_MODEL, '0},
            '{'{OP_ADVANCE, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000}, CHK_MODEL, '0},
            '{'{OP_BEGIN, 16'h0000, 16'hFFFF, 16'hFFFF, 16'h0000, 16'h5A5A}, CHK_NONE, '0},
            '{'{OP_ADVANCE, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000}, CHK_MODEL, '0},
            '{'{OP_ADVANCE, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000}, CHK_MODEL, '0},
            '{'{OP_BEGIN, 16'hFFFF, 16'h0000, 16'hFFFC, 16'h0002, 16'h00FF}, CHK_NONE, '0},
            '{'{OP_ADVANCE, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000}, CHK_MODEL, '0},
            '{'{OP_ADVANCE, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000}, CHK_MODEL, '0},
            '{'{OP_ADVANCE, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000}, CHK_MODEL, '0},
            '{'{OP_ADVANCE, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000}, CHK_MODEL, '0},
            '{'{OP_ADVANCE, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000}, CHK_MODEL, '0}
        };
    end

    initial begin
        cmd_t        c;
        logic [15:0] dxa, dya;
        int          n, ox, oy, kind, target;
        bit          drained_mid;
        drained_mid      = 1'b0;
        i_rst_n          = 1'b0;
        cmd_if.valid     = 1'b0;
        cmd_if.operation = OP_BEGIN;
        cmd_if.x_start   = '0;
        cmd_if.y_start   = '0;
        cmd_if.x_end     = '0;
        cmd_if.y_end     = '0;
        cmd_if.color     = '0;
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (plan[i]) issue_command(plan[i].cmd, plan[i].chk, plan[i].pix);
        wait_bus_drained();

        // stall the bus while advances keep coming
        hold_req = 1'b1;
        issue_command('{OP_BEGIN, 16'h0000, 16'h0000, 16'h0028, 16'h0011, 16'hC3C3});
        repeat (12) issue_command(random_cmd(OP_ADVANCE));
        wait_bus_drained();

        target = useful_items + RANDOM_ITEMS;
        while (useful_items < target) begin
            gaps_on = !(useful_items >= target - 150 && useful_items < target - 90);
            if (!drained_mid && useful_items >= target - 125) begin
                wait_bus_drained();
                drained_mid = 1'b1;
            end
            kind = $urandom_range(99);
            if (kind < 70) begin
                c  = random_cmd(OP_BEGIN);
                ox = int'($urandom_range(16)) - 8;
                oy = int'($urandom_range(16)) - 8;
                c.xe = c.xs + 16'(ox);
                c.ye = c.ys + 16'(oy);
                dxa = (c.xe >= c.xs) ? c.xe - c.xs : c.xs - c.xe;
                dya = (c.ye >= c.ys) ? c.ye - c.ys : c.ys - c.ye;
                n = int'((dxa > dya) ? dxa : dya) + 1;
                if (n > 24) n = 24;
                if ($urandom_range(99) < 15) n = $urandom_range(n - 1);
                else n += $urandom_range(2);
                issue_command(c);
                repeat (n) issue_command(random_cmd(OP_ADVANCE));
            end else if (kind < 85) begin
                issue_command(random_cmd(OP_BEGIN));
                repeat ($urandom_range(4, 1)) issue_command(random_cmd(OP_ADVANCE));
            end else begin
                repeat ($urandom_range(3, 1))
                    issue_command(random_cmd(1'($urandom_range(1))));
            end
        end
        gaps_on = 1'b1;

        wait_bus_drained();
        repeat (SETTLE) @(posedge i_clk);
        if (fail_count == 0)
            $display("line_pixel_command_stream test passed");
        else
            $display("line_pixel_command_stream test failed");
        $finish;
    end

    initial begin
        #5_000_000;
        $display("line_pixel_command_stream test failed");
        $finish;
    end

endmodule
